// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the gpio interrupt core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/gpioei_pkg.sv =====
// ---------------------------------------------------------------------------
// gpioei_pkg
// register map, bus widths and beat types of the gpio interrupt core
// ---------------------------------------------------------------------------
`default_nettype none

package gpioei_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned OFFSET_W   = 5;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 40;

    // byte offsets of the word registers
    localparam logic [OFFSET_W-1:0] OFFS_DIR    = 5'h00;
    localparam logic [OFFSET_W-1:0] OFFS_OUT    = 5'h04;
    localparam logic [OFFSET_W-1:0] OFFS_INPUT  = 5'h08;
    localparam logic [OFFSET_W-1:0] OFFS_EN     = 5'h0C;
    localparam logic [OFFSET_W-1:0] OFFS_STATUS = 5'h10;
    localparam logic [OFFSET_W-1:0] OFFS_TRIG   = 5'h14;
    localparam logic [OFFSET_W-1:0] OFFS_POL    = 5'h18;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    typedef struct packed {
        logic                write;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   data;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/gpioei_regfile.sv =====
// ---------------------------------------------------------------------------
// gpioei_regfile
// gpio register file with edge and level interrupt status update
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpioei_regfile #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    step,
    input  gpioei_pkg::access_t    access,
    output gpioei_pkg::result_t    result
);

    logic [PIN_COUNT-1:0]          dir_reg,    dir_next;
    logic [PIN_COUNT-1:0]          outv_reg,   outv_next;
    logic [PIN_COUNT-1:0]          en_reg,     en_next;
    logic [PIN_COUNT-1:0]          status_reg, status_next;
    logic [gpioei_pkg::DATA_W-1:0] trig_reg,   trig_next;
    logic [gpioei_pkg::DATA_W-1:0] pol_reg,    pol_next;

    logic [PIN_COUNT-1:0] wdata_pin;
    logic [PIN_COUNT-1:0] change;
    logic [PIN_COUNT-1:0] match;
    logic                 recompute;

    assign wdata_pin = access.data[PIN_COUNT-1:0];

    always_comb
    begin
        dir_next    = dir_reg;
        outv_next   = outv_reg;
        en_next     = en_reg;
        status_next = status_reg;
        trig_next   = trig_reg;
        pol_next    = pol_reg;
        recompute   = 1'b0;
        change      = '0;
        if (access.write == gpioei_pkg::ACC_WRITE)
        begin
            unique case (access.offset)
                gpioei_pkg::OFFS_DIR:
                begin
                    dir_next  = wdata_pin;
                    recompute = 1'b1;
                end
                gpioei_pkg::OFFS_OUT:
                begin
                    // edge mode: flag enabled output pins moving the selected way
                    if (trig_reg == '0)
                    begin
                        change = (pol_reg != '0) ? (~outv_reg & wdata_pin)
                                                 : (outv_reg & ~wdata_pin);
                        status_next = status_reg | (change & dir_reg & en_reg);
                    end
                    outv_next = wdata_pin;
                    recompute = 1'b1;
                end
                gpioei_pkg::OFFS_EN:
                begin
                    en_next   = wdata_pin;
                    recompute = 1'b1;
                end
                gpioei_pkg::OFFS_STATUS:
                begin
                    status_next = status_reg & ~wdata_pin;
                    recompute   = 1'b1;
                end
                gpioei_pkg::OFFS_TRIG:
                begin
                    trig_next = access.data;
                    recompute = 1'b1;
                end
                gpioei_pkg::OFFS_POL:
                begin
                    pol_next  = access.data;
                    recompute = 1'b1;
                end
                default:
                begin
                    recompute = 1'b0;
                end
            endcase
        end
        // level mode: output pins follow output == polarity, input pins keep status
        match = (pol_next != '0) ? outv_next : ~outv_next;
        if (recompute && (trig_next != '0))
        begin
            status_next = (status_next & ~dir_next) | (dir_next & match);
        end
    end

    always_comb
    begin
        result.read_data = '0;
        if (access.write == gpioei_pkg::ACC_READ)
        begin
            unique case (access.offset)
                gpioei_pkg::OFFS_DIR:    result.read_data = 32'(dir_reg);
                gpioei_pkg::OFFS_OUT:    result.read_data = 32'(outv_reg);
                gpioei_pkg::OFFS_INPUT:  result.read_data = 32'(outv_reg & dir_reg);
                gpioei_pkg::OFFS_EN:     result.read_data = 32'(en_reg);
                gpioei_pkg::OFFS_STATUS: result.read_data = 32'(status_reg);
                gpioei_pkg::OFFS_TRIG:   result.read_data = trig_reg;
                gpioei_pkg::OFFS_POL:    result.read_data = pol_reg;
                default:                 result.read_data = '0;
            endcase
        end
        result.irq = |(status_next & en_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg    <= '0;
            outv_reg   <= '0;
            en_reg     <= '0;
            status_reg <= '0;
            trig_reg   <= '0;
            pol_reg    <= '0;
        end
        else if (step)
        begin
            dir_reg    <= dir_next;
            outv_reg   <= outv_next;
            en_reg     <= en_next;
            status_reg <= status_next;
            trig_reg   <= trig_next;
            pol_reg    <= pol_next;
        end
    end

    `ASSERT_CLK(a_read_keeps_state, clk, rst_n, step && (access.write == gpioei_pkg::ACC_READ) |=> $stable(dir_reg) && $stable(outv_reg) && $stable(en_reg) && $stable(status_reg), "read access changed register state")
    `ASSERT_CLK(a_input_write_ignored, clk, rst_n, step && (access.write == gpioei_pkg::ACC_WRITE) && (access.offset == gpioei_pkg::OFFS_INPUT) |=> $stable(status_reg) && $stable(outv_reg), "write to input register changed state")
    `ASSERT_CLK(a_unknown_read_zero, clk, rst_n, (access.write == gpioei_pkg::ACC_READ) && (access.offset > gpioei_pkg::OFFS_POL) |-> (result.read_data == '0), "unknown offset read nonzero")

endmodule

`default_nettype wire

// ===== hdl/gpio_edge_level_interrupt_core.sv =====
// ---------------------------------------------------------------------------
// gpio_edge_level_interrupt_core
// stream front end of the gpio register block with interrupt output
// ---------------------------------------------------------------------------
// Each input beat is one register read or write; each produces one output beat
// carrying the read data (zero on writes and unknown offsets) and the interrupt
// line as it stands after the access. One access is taken every clock cycle
// while the output is not stalled; each beat passes the input register and then
// the result register, and the register file is updated as the result register loads.
// While a finished result waits on the output, the input register takes one
// more beat and then the input side stalls until the result beat is taken.
`default_nettype none
`include "assert_macros.svh"

module gpio_edge_level_interrupt_core #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [4:0] reg_offset, [36:5] write_data, [39:37] zero
    input  wire  [gpioei_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] action
    input  wire                                   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // [31:0] read_data, [32] irq_level, [39:33] zero
    output logic [gpioei_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    gpioei_pkg::access_t in_data_reg;
    logic                in_valid_reg;
    gpioei_pkg::result_t out_data_reg;
    logic                out_valid_reg;
    gpioei_pkg::result_t result;
    logic                advance;
    logic                step;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    gpioei_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .access (in_data_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg.write  <= s_axis_tuser;
            in_data_reg.offset <= s_axis_tdata[gpioei_pkg::OFFSET_W-1:0];
            in_data_reg.data   <= s_axis_tdata[gpioei_pkg::OFFSET_W +: gpioei_pkg::DATA_W];
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = gpioei_pkg::M_TDATA_W'({out_data_reg.irq, out_data_reg.read_data});

    `ASSERT_CLK(a_stall_needs_item, clk, rst_n, !s_axis_tready |-> in_valid_reg,
        "input stalled with empty input register")
    `ASSERT_CLK(a_item_not_lost, clk, rst_n, in_valid_reg && !advance |=> in_valid_reg,
        "pending access dropped during output stall")
    `ASSERT_CLK(a_result_follows, clk, rst_n, in_valid_reg && !out_valid_reg |=> out_valid_reg,
        "access did not produce a result beat")

endmodule

`default_nettype wire

// ===== tb/sv/tb_gpio_edge_level_interrupt_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_gpio_edge_level_interrupt_core
// register access stream test of the gpio interrupt core: a shadow copy of the
// register file predicts read data and interrupt line for every accepted beat,
// and each output beat is compared with the oldest prediction
// ---------------------------------------------------------------------------

class gpio_shadow;
    localparam int unsigned PINS = 32;
    localparam logic [63:0] PIN_MASK64 = (64'd1 << PINS) - 64'd1;
    localparam logic [gpioei_pkg::DATA_W-1:0] PIN_MASK =
        PIN_MASK64[gpioei_pkg::DATA_W-1:0];

    logic [gpioei_pkg::DATA_W-1:0] dir_reg;
    logic [gpioei_pkg::DATA_W-1:0] out_reg;
    logic [gpioei_pkg::DATA_W-1:0] en_reg;
    logic [gpioei_pkg::DATA_W-1:0] status_reg;
    logic [gpioei_pkg::DATA_W-1:0] trig_reg;
    logic [gpioei_pkg::DATA_W-1:0] pol_reg;
    gpioei_pkg::result_t           pending_results[$];
    int                            errors;

    function new();
        dir_reg    = '0;
        out_reg    = '0;
        en_reg     = '0;
        status_reg = '0;
        trig_reg   = '0;
        pol_reg    = '0;
        errors     = 0;
    endfunction

    // level mode: output pins follow "output equals polarity", input pins keep status
    function void refresh_level_status();
        logic [gpioei_pkg::DATA_W-1:0] hit;
        hit = (pol_reg != '0) ? out_reg : ~out_reg;
        if (trig_reg != '0)
            status_reg = ((status_reg & ~dir_reg) | (dir_reg & hit)) & PIN_MASK;
    endfunction

    function void apply_access(logic is_write, logic [gpioei_pkg::OFFSET_W-1:0] offs,
                               logic [gpioei_pkg::DATA_W-1:0] wdata);
        gpioei_pkg::result_t           res;
        logic [gpioei_pkg::DATA_W-1:0] next_out;
        logic [gpioei_pkg::DATA_W-1:0] moved;
        logic                          known;
        res.read_data = '0;
        known = 1'b1;
        if (is_write == gpioei_pkg::ACC_WRITE)
        begin
            case (offs)
                gpioei_pkg::OFFS_DIR:    dir_reg = wdata & PIN_MASK;
                gpioei_pkg::OFFS_OUT:
                begin
                    next_out = wdata & PIN_MASK;
                    if (trig_reg == '0)
                    begin
                        moved = (pol_reg != '0) ? (~out_reg & next_out)
                                                : (out_reg & ~next_out);
                        status_reg = (status_reg | (moved & dir_reg & en_reg)) & PIN_MASK;
                    end
                    out_reg = next_out;
                end
                gpioei_pkg::OFFS_EN:     en_reg = wdata & PIN_MASK;
                gpioei_pkg::OFFS_STATUS: status_reg = status_reg & ~wdata;
                gpioei_pkg::OFFS_TRIG:   trig_reg = wdata;
                gpioei_pkg::OFFS_POL:    pol_reg = wdata;
                default:                 known = 1'b0;
            endcase
            if (known)
                refresh_level_status();
        end
        else
        begin
            case (offs)
                gpioei_pkg::OFFS_DIR:    res.read_data = dir_reg;
                gpioei_pkg::OFFS_OUT:    res.read_data = out_reg;
                gpioei_pkg::OFFS_INPUT:  res.read_data = out_reg & dir_reg;
                gpioei_pkg::OFFS_EN:     res.read_data = en_reg;
                gpioei_pkg::OFFS_STATUS: res.read_data = status_reg;
                gpioei_pkg::OFFS_TRIG:   res.read_data = trig_reg;
                gpioei_pkg::OFFS_POL:    res.read_data = pol_reg;
                default:                 res.read_data = '0;
            endcase
        end
        res.irq = ((status_reg & en_reg) != '0);
        pending_results.push_back(res);
    endfunction

    function void compare_beat(logic [gpioei_pkg::M_TDATA_W-1:0] beat);
        gpioei_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            $error("output beat with nothing pending: tdata=%h", beat);
            errors++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (beat[gpioei_pkg::DATA_W-1:0] !== want.read_data)
            begin
                $error("read_data: expected %h, actual %h", want.read_data,
                       beat[gpioei_pkg::DATA_W-1:0]);
                errors++;
            end
            if (beat[gpioei_pkg::DATA_W] !== want.irq)
            begin
                $error("irq_level: expected %b, actual %b", want.irq,
                       beat[gpioei_pkg::DATA_W]);
                errors++;
            end
        end
    endfunction
endclass

module tb_gpio_edge_level_interrupt_core;

    localparam int unsigned STALL_LIMIT = 1000;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [gpioei_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [gpioei_pkg::M_TDATA_W-1:0] m_axis_tdata;

    gpio_shadow shadow;
    bit         no_gaps;

    gpio_edge_level_interrupt_core #(
        .PIN_COUNT (32)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [gpioei_pkg::OFFSET_W-1:0] reg_offset_at(int unsigned idx);
        case (idx)
            0:       return gpioei_pkg::OFFS_DIR;
            1:       return gpioei_pkg::OFFS_OUT;
            2:       return gpioei_pkg::OFFS_INPUT;
            3:       return gpioei_pkg::OFFS_EN;
            4:       return gpioei_pkg::OFFS_STATUS;
            5:       return gpioei_pkg::OFFS_TRIG;
            default: return gpioei_pkg::OFFS_POL;
        endcase
    endfunction

    task automatic send_access(logic is_write, logic [gpioei_pkg::OFFSET_W-1:0] offs,
                               logic [gpioei_pkg::DATA_W-1:0] wdata);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_write;
        s_axis_tdata  <= {3'b000, wdata, offs};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random_access();
        logic                            is_write;
        logic [gpioei_pkg::OFFSET_W-1:0] offs;
        logic [gpioei_pkg::DATA_W-1:0]   wdata;
        int unsigned                     bit_pos;
        bit_pos  = $urandom_range(0, 31);
        is_write = ($urandom_range(0, 99) < 55) ? gpioei_pkg::ACC_WRITE
                                                 : gpioei_pkg::ACC_READ;
        if ($urandom_range(0, 99) < 88)
            offs = reg_offset_at($urandom_range(0, 6));
        else
            offs = gpioei_pkg::OFFSET_W'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0:       wdata = '0;
            1:       wdata = '1;
            2:       wdata = 32'd1 << bit_pos;
            3:       wdata = ~(32'd1 << bit_pos);
            4:       wdata = $urandom & $urandom;
            5:       wdata = $urandom | $urandom;
            default: wdata = $urandom;
        endcase
        // keep edge mode and falling polarity common so edges get exercised
        if ((offs == gpioei_pkg::OFFS_TRIG || offs == gpioei_pkg::OFFS_POL)
            && $urandom_range(0, 1) == 0)
            wdata = '0;
        send_access(is_write, offs, wdata);
    endtask

    // output side: random stalls per beat
    initial
    begin
        int unsigned gap;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                shadow.apply_access(s_axis_tuser, s_axis_tdata[gpioei_pkg::OFFSET_W-1:0],
                                    s_axis_tdata[gpioei_pkg::OFFSET_W +: gpioei_pkg::DATA_W]);
            if (m_axis_tvalid && m_axis_tready)
                shadow.compare_beat(m_axis_tdata);
        end
    end

    // watchdog on cycles without any beat moving
    initial
    begin
        int unsigned idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !rst_n)
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        shadow        = new();
        no_gaps       = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= gpioei_pkg::ACC_READ;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of every register
        for (int unsigned i = 0; i < 7; i++)
            send_access(gpioei_pkg::ACC_READ, reg_offset_at(i), 32'hFFFF_FFFF);
        // edge mode, falling polarity
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_DIR, 32'hFFFF_FFFF);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_EN, 32'hFFFF_FFFF);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_OUT, 32'hFFFF_FFFF);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_OUT, 32'h0000_0000);
        send_access(gpioei_pkg::ACC_READ, gpioei_pkg::OFFS_STATUS, 32'h0);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_STATUS, 32'hFFFF_FFFF);
        // rising polarity with only the top bit set
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_POL, 32'h8000_0000);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_OUT, 32'hA5A5_A5A5);
        // input register is read-only
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_INPUT, 32'hFFFF_FFFF);
        send_access(gpioei_pkg::ACC_READ, gpioei_pkg::OFFS_INPUT, 32'h0);
        // level mode recompute on every known write
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_TRIG, 32'h0000_0001);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_DIR, 32'h0000_FFFF);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_STATUS, 32'hFFFF_FFFF);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_POL, 32'h0000_0000);
        // unknown and unaligned offsets
        send_access(gpioei_pkg::ACC_READ, 5'h1C, 32'h0);
        send_access(gpioei_pkg::ACC_WRITE, 5'h1F, 32'hFFFF_FFFF);
        send_access(gpioei_pkg::ACC_READ, 5'h02, 32'h0);
        send_access(gpioei_pkg::ACC_WRITE, gpioei_pkg::OFFS_TRIG, 32'h0000_0000);

        for (int phase = 0; phase < 15; phase++)
        begin
            no_gaps = (phase % 4 == 3);
            repeat (95) send_random_access();
        end
        no_gaps = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (shadow.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
